@@ hdl/slpd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slpd_pkg
// Shared widths, codes and control types of the short/long press detector.
// ----------------------------------------------------------------------------
package slpd_pkg;

    // Field widths.
    localparam int CODE_BITS     = 8;
    localparam int TIME_BITS     = 16;
    localparam int EVENT_BITS    = 2;
    localparam int PROG_BITS     = 9;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // The Q8 quotient is found one bit per divider step.
    localparam int DIV_STEPS = PROG_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);

    // Press event codes.
    localparam logic [EVENT_BITS-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_BITS-1:0] EV_SHORT = 2'd1;
    localparam logic [EVENT_BITS-1:0] EV_LONG  = 2'd2;

    // Progress value that means complete.
    localparam logic [PROG_BITS-1:0] PROG_FULL = 9'd256;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_CODE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TICKS   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_WINDOW = 2'd2;

    // Register reset values.
    localparam logic [CODE_BITS-1:0] TARGET_RESET = 8'd1;
    localparam logic [TIME_BITS-1:0] HOLD_RESET   = 16'd1000;
    localparam logic [TIME_BITS-1:0] SHORT_RESET  = 16'd300;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic div_step;
        logic push;
    } t_slpd_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_slpd_sts;

endpackage : slpd_pkg
`default_nettype wire

@@ hdl/slpd_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slpd_in_if
// Input channel: one sampled code and the ticks since the previous sample.
// ----------------------------------------------------------------------------
interface slpd_in_if;
    logic                            valid;
    logic                            ready;
    logic [slpd_pkg::CODE_BITS-1:0]  next_code;
    logic [slpd_pkg::TIME_BITS-1:0]  delta_ticks;

    modport source (output valid, output next_code, output delta_ticks, input ready);
    modport sink   (input valid, input next_code, input delta_ticks, output ready);
endinterface : slpd_in_if
`default_nettype wire

@@ hdl/slpd_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slpd_out_if
// Output channel: press event, Q8 progress and long phase flag.
// ----------------------------------------------------------------------------
interface slpd_out_if;
    logic                            valid;
    logic                            ready;
    logic [slpd_pkg::EVENT_BITS-1:0] press_event;
    logic [slpd_pkg::PROG_BITS-1:0]  progress;
    logic                            long_phase;

    modport source (output valid, output press_event, output progress,
                    output long_phase, input ready);
    modport sink   (input valid, input press_event, input progress,
                    input long_phase, output ready);
endinterface : slpd_out_if
`default_nettype wire

@@ hdl/short_long_press_detector_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// short_long_press_detector_top
// Short/long press qualifier for one target code with Q8 long-press progress.
// ----------------------------------------------------------------------------
// Flow: an accepted word's result is pushed into the output register, after the
// 9 steps of the serial restoring divider when the Q8 progress is divided out.
// The controller takes one word at a time: the next word is taken only after
// the push, which waits while the output register is full.
// Reset: synchronous, active low; registers return to their defaults and the
// press state and output valid are cleared.
// ----------------------------------------------------------------------------
module short_long_press_detector_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [slpd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire [slpd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    slpd_in_if.sink                           i_in,
    slpd_out_if.source                        o_out
);
    import slpd_pkg::*;

    t_slpd_cmd w_cmd;
    t_slpd_sts w_sts;
    logic      w_in_ready;

    assign i_in.ready = w_in_ready;

    slpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    slpd_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_next_code   (i_in.next_code),
        .i_delta_ticks (i_in.delta_ticks),
        .i_out_ready   (o_out.ready),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_out.valid),
        .o_press_event (o_out.press_event),
        .o_progress    (o_out.progress),
        .o_long_phase  (o_out.long_phase)
    );

    // A result is only pushed into a free output register.
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> w_sts.out_free)
        else $error("result pushed into a full output register");

    // The controller works on one word at a time.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("word accepted while the previous one is in work");

    // A fired long press always reports full progress.
    a_long_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.press_event == EV_LONG)) |-> (o_out.progress == PROG_FULL))
        else $error("long press without full progress");

    // Progress never exceeds complete and no undefined event code appears.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.progress <= PROG_FULL) && (o_out.press_event <= EV_LONG)))
        else $error("result out of range");

endmodule : short_long_press_detector_top
`default_nettype wire

@@ hdl/slpd_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slpd_ctrl
// Controller: accepts a word, runs the serial divider when needed and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module slpd_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  slpd_pkg::t_slpd_sts  i_sts,
    output logic                 o_in_ready,
    output slpd_pkg::t_slpd_cmd  o_cmd
);
    import slpd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUSH
    } t_state;

    t_state              r_state;
    logic                r_ready;
    logic [CNT_BITS-1:0] r_count;

    // Commands follow from the state and the handshakes.
    always_comb begin
        o_cmd.accept   = r_ready && i_in_valid;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.push     = (r_state == S_PUSH) && i_sts.out_free;
    end

    assign o_in_ready = r_ready;

    // State register with the registered ready flag and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ready <= 1'b0;
                        r_count <= '0;
                        r_state <= i_sts.need_div ? S_DIV : S_PUSH;
                    end
                end
                S_DIV: begin
                    if (r_count == CNT_BITS'(DIV_STEPS - 1)) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
                S_PUSH: begin
                    if (i_sts.out_free) begin
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_ready <= 1'b1;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule : slpd_ctrl
`default_nettype wire

@@ hdl/slpd_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slpd_dpath
// Datapath: configuration and press state, the one-bit-per-step restoring
// divider for the Q8 progress, and the output register.
// ----------------------------------------------------------------------------
module slpd_dpath (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [slpd_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire [slpd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire [slpd_pkg::CODE_BITS-1:0]    i_next_code,
    input  wire [slpd_pkg::TIME_BITS-1:0]    i_delta_ticks,
    input  wire                              i_out_ready,
    input  slpd_pkg::t_slpd_cmd              i_cmd,
    output slpd_pkg::t_slpd_sts              o_sts,
    output logic                             o_out_valid,
    output logic [slpd_pkg::EVENT_BITS-1:0]  o_press_event,
    output logic [slpd_pkg::PROG_BITS-1:0]   o_progress,
    output logic                             o_long_phase
);
    import slpd_pkg::*;

    // Configuration registers.
    logic [CODE_BITS-1:0] r_target;
    logic [TIME_BITS-1:0] r_hold;
    logic [TIME_BITS-1:0] r_short;

    // Press state.
    logic [CODE_BITS-1:0] r_last_code, n_last_code;
    logic [TIME_BITS-1:0] r_held, n_held;
    logic                 r_fired, n_fired;
    logic                 r_lphase, n_lphase;

    // Pending result and divider.
    logic [EVENT_BITS-1:0] r_pend_event, n_pend_event;
    logic [PROG_BITS-1:0]  r_pend_prog, n_pend_prog;
    logic                  r_use_q;
    logic [TIME_BITS:0]    r_rem;
    logic [TIME_BITS-1:0]  r_den;
    logic [PROG_BITS-1:0]  r_quot;

    // Output register.
    logic                  r_out_valid;
    logic [EVENT_BITS-1:0] r_out_event;
    logic [PROG_BITS-1:0]  r_out_prog;
    logic                  r_out_lphase;

    logic [TIME_BITS:0]    w_sum;
    logic [TIME_BITS-1:0]  w_t;
    logic                  w_too_long;
    logic                  w_need_div;
    logic [TIME_BITS-1:0]  w_num;
    logic [TIME_BITS-1:0]  w_den;
    logic                  w_ge;
    logic [TIME_BITS:0]    w_diff;

    // Saturating hold time and the short-press qualifier.
    always_comb begin
        w_sum      = {1'b0, r_held} + {1'b0, i_delta_ticks};
        w_t        = w_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : w_sum[TIME_BITS-1:0];
        w_too_long = (r_short != '0) && (r_held > r_short);
        w_num      = w_t - r_short;
        w_den      = r_hold - r_short;
    end

    // Next press state and the pending result of the word on the input.
    always_comb begin
        n_last_code  = r_last_code;
        n_held       = r_held;
        n_fired      = r_fired;
        n_lphase     = r_lphase;
        n_pend_event = EV_NONE;
        n_pend_prog  = '0;
        w_need_div   = 1'b0;
        if (i_next_code != r_last_code) begin
            // A change of code ends the press.
            if ((r_last_code == r_target) && !w_too_long && !r_fired) begin
                n_pend_event = EV_SHORT;
            end
            n_last_code = i_next_code;
            n_held      = '0;
            n_fired     = 1'b0;
            n_lphase    = 1'b0;
        end else if ((i_next_code == r_target) && !r_fired) begin
            // Target still held: accumulate and check both windows.
            n_held = w_t;
            if (w_t > r_short) begin
                n_lphase = 1'b1;
            end
            if (w_t > r_hold) begin
                n_held       = '0;
                n_fired      = 1'b1;
                n_lphase     = 1'b0;
                n_pend_event = EV_LONG;
                n_pend_prog  = PROG_FULL;
            end else if ((r_hold > r_short) && (w_t >= r_short)) begin
                w_need_div = 1'b1;
            end
        end
    end

    // Restoring divider step: compare, subtract, shift.
    always_comb begin
        w_ge   = (r_rem >= {1'b0, r_den});
        w_diff = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;
    end

    always_comb begin
        o_sts.need_div = w_need_div;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    // Configuration and press state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= TARGET_RESET;
            r_hold      <= HOLD_RESET;
            r_short     <= SHORT_RESET;
            r_last_code <= '0;
            r_held      <= '0;
            r_fired     <= 1'b0;
            r_lphase    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TARGET_CODE:  r_target <= i_cfg_data[CODE_BITS-1:0];
                    REG_HOLD_TICKS:   r_hold   <= i_cfg_data[TIME_BITS-1:0];
                    REG_SHORT_WINDOW: r_short  <= i_cfg_data[TIME_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_last_code <= n_last_code;
                r_held      <= n_held;
                r_fired     <= n_fired;
                r_lphase    <= n_lphase;
            end
        end
    end

    // Pending result and divider registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_event <= n_pend_event;
            r_pend_prog  <= n_pend_prog;
            r_use_q      <= w_need_div;
            r_rem        <= {1'b0, w_num};
            r_den        <= w_den;
        end else if (i_cmd.div_step) begin
            r_rem  <= {w_diff[TIME_BITS-1:0], 1'b0};
            r_quot <= {r_quot[PROG_BITS-2:0], w_ge};
        end
    end

    // Output register, freed when the sink takes the word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_event  <= r_pend_event;
            r_out_prog   <= r_use_q ? r_quot : r_pend_prog;
            r_out_lphase <= r_lphase;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_press_event = r_out_event;
    assign o_progress    = r_out_prog;
    assign o_long_phase  = r_out_lphase;

endmodule : slpd_dpath
`default_nettype wire

@@ tb/sv/slpd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slpd_checker
// Watches the configuration port and both channels of the press detector.
// Keeps its own copy of the thresholds and the press state, works out the
// result of every accepted sample word, and compares each accepted result
// word field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module slpd_checker
    import slpd_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_BITS-1:0]  i_cfg_data,
    slpd_in_if                       in_ch,
    slpd_out_if                      out_ch,
    output int                       o_errors,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [EVENT_BITS-1:0] press_event;
        logic [PROG_BITS-1:0]  progress;
        logic                  long_phase;
    } t_press_result;

    // Shadow copy of the thresholds.
    logic [CODE_BITS-1:0] tgt_code;
    logic [TIME_BITS-1:0] hold_lim;
    logic [TIME_BITS-1:0] win_ticks;

    // Shadow copy of the press state.
    logic [CODE_BITS-1:0] prev_code;
    logic [TIME_BITS-1:0] held;
    logic                 fired;
    logic                 long_ph;

    t_press_result expected_presses[$];

    // Qualify one sample against the current press and advance the press state.
    function automatic t_press_result qualify_sample(input logic [CODE_BITS-1:0] code,
                                                     input logic [TIME_BITS-1:0] dt);
        t_press_result r;
        logic [TIME_BITS:0]   sum;
        logic [TIME_BITS-1:0] t;
        int unsigned          q;
        r = '0;
        r.press_event = EV_NONE;
        if (code != prev_code) begin
            // A code change ends the press; a quick release of the target is a short press.
            if (prev_code == tgt_code && !fired &&
                !((win_ticks != '0) && (held > win_ticks))) begin
                r.press_event = EV_SHORT;
            end
            prev_code = code;
            held      = '0;
            fired     = 1'b0;
            long_ph   = 1'b0;
        end else if (code == tgt_code && !fired) begin
            // Accumulate the hold time, saturating at full scale.
            sum  = {1'b0, held} + {1'b0, dt};
            t    = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
            held = t;
            if (t > win_ticks) begin
                long_ph = 1'b1;
            end
            if (t > hold_lim) begin
                held          = '0;
                fired         = 1'b1;
                long_ph       = 1'b0;
                r.press_event = EV_LONG;
                r.progress    = PROG_FULL;
            end else if (hold_lim > win_ticks && t >= win_ticks) begin
                q = ((32'(t) - 32'(win_ticks)) << 8) / (32'(hold_lim) - 32'(win_ticks));
                if (q > 32'(PROG_FULL)) begin
                    q = 32'(PROG_FULL);
                end
                r.progress = q[PROG_BITS-1:0];
            end
        end
        r.long_phase = long_ph;
        return r;
    endfunction

    // Track configuration, predict on input words, compare on output words.
    always @(posedge i_clk) begin
        t_press_result want;
        if (!i_rst_n) begin
            tgt_code  = TARGET_RESET;
            hold_lim  = HOLD_RESET;
            win_ticks = SHORT_RESET;
            prev_code = '0;
            held      = '0;
            fired     = 1'b0;
            long_ph   = 1'b0;
            expected_presses.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TARGET_CODE:  tgt_code  = i_cfg_data[CODE_BITS-1:0];
                    REG_HOLD_TICKS:   hold_lim  = i_cfg_data[TIME_BITS-1:0];
                    REG_SHORT_WINDOW: win_ticks = i_cfg_data[TIME_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_presses.push_back(qualify_sample(in_ch.next_code, in_ch.delta_ticks));
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_presses.size() == 0) begin
                    $display("%0t: unexpected result word event=%0d progress=%0d long=%0d",
                             $time, out_ch.press_event, out_ch.progress, out_ch.long_phase);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_presses.pop_front();
                    if (want.press_event !== out_ch.press_event ||
                        want.progress !== out_ch.progress ||
                        want.long_phase !== out_ch.long_phase) begin
                        $display("%0t: mismatch expected event=%0d progress=%0d long=%0d",
                                 $time, want.press_event, want.progress, want.long_phase);
                        $display("%0t:          actual   event=%0d progress=%0d long=%0d",
                                 $time, out_ch.press_event, out_ch.progress,
                                 out_ch.long_phase);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= expected_presses.size();
        end
    end

endmodule : slpd_checker
`default_nettype wire

@@ tb/sv/tb_short_long_press_detector_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_short_long_press_detector_top
// Drives the press detector with directed presses that hit the window edges,
// saturation and firing, then with random well-formed presses and noise over
// several threshold settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_short_long_press_detector_top;
    import slpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SET = 9;
    localparam int WORDS_PER_SET = 190;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     idle_on;
    int                       errors;
    int                       pending;

    slpd_in_if  in_ch();
    slpd_out_if out_ch();

    short_long_press_detector_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    slpd_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always #1 i_clk = ~i_clk;

    // Give up if the run hangs.
    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stall before taking each word.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        forever begin
            gap = idle_on ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    // Send one sample word after a random gap; returns at the falling edge after it is taken.
    task automatic send_word(input logic [CODE_BITS-1:0] code, input logic [TIME_BITS-1:0] dt);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.next_code   = code;
        in_ch.delta_ticks = dt;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every predicted result word has come back.
    task automatic wait_all_results();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write all three thresholds, one register per cycle.
    task automatic program_thresholds(input logic [CODE_BITS-1:0] tgt,
                                      input logic [TIME_BITS-1:0] hold,
                                      input logic [TIME_BITS-1:0] win);
        cfg_we   = 1'b1;
        cfg_idx  = REG_TARGET_CODE;
        cfg_data = CFG_DATA_BITS'(tgt);
        @(negedge i_clk);
        cfg_idx  = REG_HOLD_TICKS;
        cfg_data = hold;
        @(negedge i_clk);
        cfg_idx  = REG_SHORT_WINDOW;
        cfg_data = win;
        @(negedge i_clk);
        cfg_we   = 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly deltas on the scale of the thresholds, sometimes zero or full range.
    function automatic logic [TIME_BITS-1:0] pick_delta(input int span);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return TIME_BITS'($urandom_range(0, 65535));
        end else if (sel == 1) begin
            return '0;
        end
        return TIME_BITS'($urandom_range(0, span));
    endfunction

    // Random presses of the target with random hold steps, mixed with noise codes.
    task automatic run_press_traffic(input logic [CODE_BITS-1:0] tgt, input int hold,
                                     input int win, input int n);
        int sent;
        int reps;
        int span;
        logic [CODE_BITS-1:0] rel;
        sent = 0;
        span = ((hold > win) ? hold : win) / 3 + 2;
        if (span > 65535) begin
            span = 65535;
        end
        while (sent < n) begin
            if ($urandom_range(0, 9) < 7) begin
                send_word(tgt, pick_delta(span));
                reps = $urandom_range(0, 8);
                repeat (reps) send_word(tgt, pick_delta(span));
                if ($urandom_range(0, 3) == 0) begin
                    rel = CODE_BITS'($urandom_range(0, 255));
                end else begin
                    rel = (tgt == '0) ? CODE_BITS'(1) : '0;
                end
                send_word(rel, pick_delta(span));
                sent = sent + reps + 2;
            end else begin
                send_word(CODE_BITS'($urandom_range(0, 255)), TIME_BITS'($urandom_range(0, 65535)));
                sent++;
            end
            // Now and then let the pipeline run dry.
            if ($urandom_range(0, 39) == 0) begin
                wait_all_results();
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        logic [CODE_BITS-1:0] set_tgt[N_SET];
        int                   set_hold[N_SET];
        int                   set_win[N_SET];
        set_tgt  = '{8'd1, 8'd0, 8'd255, 8'd255, 8'd7, 8'd3, 8'd1, 8'd200, 8'd12};
        set_hold = '{1000, 0, 65535, 65535, 100, 50, 20, 65535, 4000};
        set_win  = '{300, 0, 65535, 0, 100, 200, 5, 1, 300};
        set_tgt[N_SET-1]  = CODE_BITS'($urandom_range(0, 255));
        set_hold[N_SET-1] = $urandom_range(0, 65535);
        set_win[N_SET-1]  = $urandom_range(0, 65535);

        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = REG_TARGET_CODE;
        cfg_data          = '0;
        idle_on           = 1'b1;
        in_ch.valid       = 1'b0;
        in_ch.next_code   = '0;
        in_ch.delta_ticks = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Default thresholds: target 1, long press past 1000, short window 300.
        send_word(8'd0, 16'd0);
        send_word(8'd1, 16'd65535);
        send_word(8'd1, 16'd100);
        send_word(8'd1, 16'd200);
        send_word(8'd1, 16'd350);
        send_word(8'd1, 16'd350);
        send_word(8'd1, 16'd1);
        send_word(8'd1, 16'd65535);
        send_word(8'd0, 16'd0);
        send_word(8'd1, 16'd0);
        send_word(8'd1, 16'd300);
        send_word(8'd0, 16'd170);
        send_word(8'd1, 16'd85);
        send_word(8'd1, 16'd301);
        send_word(8'd2, 16'd0);
        send_word(8'd2, 16'd500);
        send_word(8'd255, 16'd65535);
        send_word(8'd128, 16'd32768);

        // Hold time saturating at full scale, then a release inside the window.
        wait_all_results();
        program_thresholds(8'd255, 16'd65535, 16'd65535);
        send_word(8'd255, 16'd0);
        send_word(8'd255, 16'd65535);
        send_word(8'd255, 16'd65535);
        send_word(8'd0, 16'd0);

        // Equal windows: no progress until the long press fires.
        wait_all_results();
        program_thresholds(8'd7, 16'd100, 16'd100);
        send_word(8'd7, 16'd0);
        send_word(8'd7, 16'd100);
        send_word(8'd7, 16'd1);
        send_word(8'd0, 16'd0);

        // Short window disabled: a long hold still releases as a short press.
        wait_all_results();
        program_thresholds(8'd1, 16'd1000, 16'd0);
        send_word(8'd1, 16'd0);
        send_word(8'd1, 16'd500);
        send_word(8'd0, 16'd0);

        // Random traffic over each threshold setting.
        for (int p = 0; p < N_SET; p++) begin
            wait_all_results();
            idle_on = (p % 3 != 2);
            program_thresholds(set_tgt[p], TIME_BITS'(set_hold[p]), TIME_BITS'(set_win[p]));
            run_press_traffic(set_tgt[p], set_hold[p], set_win[p], WORDS_PER_SET);
        end

        wait_all_results();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule : tb_short_long_press_detector_top
`default_nettype wire
